>>> hdl/fup_pkg.sv
// ----------------------------------------------------------------------------
// fup_pkg
// Shared types, constants and helpers for the form-urlencoded pair parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fup_pkg;

	// Configuration register file
	localparam int LIMIT_W = 10;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 1'b1;
	localparam logic [LIMIT_W-1:0] KEY_LIMIT_RST = 10'd255;
	localparam logic [LIMIT_W-1:0] VALUE_LIMIT_RST = 10'd399;

	// Default width of the per-part length counters
	localparam int LENGTH_WIDTH_DEF = 10;

	// Delimiter characters
	localparam logic [7:0] CH_AMP = 8'h26;  // '&'
	localparam logic [7:0] CH_EQ = 8'h3D;  // '='
	localparam logic [7:0] CH_PCT = 8'h25;  // '%'

	localparam logic [15:0] PAIR_CNT_MAX = 16'hFFFF;

	// Escape sequencer: idle, waiting for first digit, waiting for second digit
	typedef enum logic [2:0] {
		ESC_NONE = 3'b001,
		ESC_D1 = 3'b010,
		ESC_D2 = 3'b100
	} esc_phase_t;

	typedef struct packed {
		esc_phase_t phase;
		logic [7:0] accum;
		logic stopped;
	} esc_state_t;

	// Parser context, apart from the length counters
	typedef struct packed {
		logic in_value;
		logic key_over;
		logic value_over;
		logic [15:0] pair_cnt;
		esc_state_t esc;
	} fup_ctx_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic in_last;
	} fup_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic byte_valid;
		logic is_value;
		logic pair_end;
		logic key_overflowed;
		logic value_overflowed;
		logic [15:0] pair_number;
	} fup_out_t;

	// Hex digit decode: {is_hex, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/form_urlencoded_pair_parser.sv
// A transaction accepted into the input register has its result (if any) loaded
// into the output register when it retires from stage 1.
// Throughput: one byte per cycle while the output side does not stall; one input
// register and one output register separate the two handshakes.
// Reset (arst_n low, asynchronous): parser context, counters and valids clear;
// limits return to key 255, value 399.
// ----------------------------------------------------------------------------
// form_urlencoded_pair_parser
// Streaming decoder for form-urlencoded text: splits pairs, tags key/value bytes,
// decodes %XX escapes and enforces per-part length limits.
// ----------------------------------------------------------------------------
`default_nettype none

module form_urlencoded_pair_parser #(
	parameter int LENGTH_WIDTH = fup_pkg::LENGTH_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// input byte stream
	input wire logic in_valid,
	output logic in_stall,
	input wire fup_pkg::fup_in_t in_data,
	// decoded result stream
	output logic out_valid,
	input wire logic out_stall,
	output fup_pkg::fup_out_t out_data,
	// configuration writes
	input wire logic cfg_we,
	input wire logic [fup_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [fup_pkg::LIMIT_W-1:0] cfg_data
);
	import fup_pkg::*;

	logic [LIMIT_W-1:0] key_limit;
	logic [LIMIT_W-1:0] value_limit;

	// Input register (stage 1)
	logic valid_s1;
	fup_in_t item_s1;

	// Parser context, updated once per byte as it leaves stage 1
	fup_ctx_t ctx_q;
	fup_ctx_t ctx_d;
	logic [LENGTH_WIDTH-1:0] key_len_q, key_len_d;
	logic [LENGTH_WIDTH-1:0] val_len_q, val_len_d;

	// Step output
	logic res_valid;
	fup_out_t res;

	// Output register
	logic out_valid_q;
	fup_out_t out_data_q;

	logic adv;

	fup_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.key_limit(key_limit),
		.value_limit(value_limit)
	);

	fup_step #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_step (
		.ctx_q(ctx_q),
		.key_len_q(key_len_q),
		.val_len_q(val_len_q),
		.key_limit(key_limit),
		.value_limit(value_limit),
		.item(item_s1),
		.ctx_d(ctx_d),
		.key_len_d(key_len_d),
		.val_len_d(val_len_d),
		.res_valid(res_valid),
		.res(res)
	);

	// Stage 1 retires when the output register is empty or draining this cycle.
	// Bytes that produce no result (a first escape digit, a key '=', a '%') retire without a slot.
	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Context commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.in_value <= 1'b0;
			ctx_q.key_over <= 1'b0;
			ctx_q.value_over <= 1'b0;
			ctx_q.pair_cnt <= 16'h0000;
			ctx_q.esc.phase <= ESC_NONE;
			ctx_q.esc.accum <= 8'h00;
			ctx_q.esc.stopped <= 1'b0;
			key_len_q <= '0;
			val_len_q <= '0;
		end else if (adv) begin
			ctx_q <= ctx_d;
			key_len_q <= key_len_d;
			val_len_q <= val_len_d;
		end
	end

	// Output register: loads on a retiring byte with a result, clears on drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// A pair end always leaves a fresh key part with no escape in flight
	a_pair_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_valid && res.pair_end) |=>
		(key_len_q == '0 && val_len_q == '0 && !ctx_q.in_value
			&& ctx_q.esc.phase == ESC_NONE))
		else $error("context not cleared after pair end");

	// Every result carries a byte or a pair end; no byte means a zero byte field
	a_result_content: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.byte_valid) |->
		(out_data_q.pair_end && out_data_q.out_byte == 8'h00))
		else $error("empty or dirty result transaction");

	// End of text restarts pair numbering
	a_last_restarts_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.in_last) |=> (ctx_q.pair_cnt == 16'h0000))
		else $error("pair counter not restarted at end of text");

endmodule

`default_nettype wire

>>> hdl/fup_cfg.sv
// ----------------------------------------------------------------------------
// fup_cfg
// Limit registers written through the plain configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module fup_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [fup_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [fup_pkg::LIMIT_W-1:0] cfg_data,
	output logic [fup_pkg::LIMIT_W-1:0] key_limit,
	output logic [fup_pkg::LIMIT_W-1:0] value_limit
);
	import fup_pkg::*;

	logic [LIMIT_W-1:0] key_limit_q;
	logic [LIMIT_W-1:0] value_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_limit_q <= KEY_LIMIT_RST;
			value_limit_q <= VALUE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_LIMIT: begin
					key_limit_q <= cfg_data;
				end
				CFG_VALUE_LIMIT: begin
					value_limit_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign key_limit = key_limit_q;
	assign value_limit = value_limit_q;

endmodule

`default_nettype wire

>>> hdl/fup_step.sv
// ----------------------------------------------------------------------------
// fup_step
// Single-byte parse step: next context and the optional result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module fup_step #(
	parameter int LENGTH_WIDTH = fup_pkg::LENGTH_WIDTH_DEF
) (
	input wire fup_pkg::fup_ctx_t ctx_q,
	input wire logic [LENGTH_WIDTH-1:0] key_len_q,
	input wire logic [LENGTH_WIDTH-1:0] val_len_q,
	input wire logic [fup_pkg::LIMIT_W-1:0] key_limit,
	input wire logic [fup_pkg::LIMIT_W-1:0] value_limit,
	input wire fup_pkg::fup_in_t item,
	output fup_pkg::fup_ctx_t ctx_d,
	output logic [LENGTH_WIDTH-1:0] key_len_d,
	output logic [LENGTH_WIDTH-1:0] val_len_d,
	output logic res_valid,
	output fup_pkg::fup_out_t res
);
	import fup_pkg::*;

	localparam int CW = (LENGTH_WIDTH > LIMIT_W) ? LENGTH_WIDTH : LIMIT_W;
	localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

	logic [7:0] b;
	logic is_amp, is_sep, delim, esc, is_pct;
	logic [4:0] hx;
	logic [7:0] accum_new;
	logic stopped_new;
	logic emit_try;
	logic [7:0] ob;
	logic [LENGTH_WIDTH-1:0] part_len;
	logic [LIMIT_W-1:0] part_lim;
	logic keep, have_byte, drop, end_pair;
	logic key_over_new, value_over_new, in_value_new;

	always_comb begin
		b = item.in_byte;
		is_amp = (b == CH_AMP);
		is_sep = (b == CH_EQ) && !ctx_q.in_value;
		delim = is_amp || is_sep;
		is_pct = (b == CH_PCT);
		esc = (ctx_q.esc.phase != ESC_NONE);
		hx = hex_decode(b);

		accum_new = (hx[4] && !ctx_q.esc.stopped) ? {ctx_q.esc.accum[3:0], hx[3:0]}
			: ctx_q.esc.accum;
		stopped_new = ctx_q.esc.stopped | !hx[4];

		// Byte to emit: cut escape, completed or end-cut escape, none for a delimiter, empty escape, plain
		if (esc && delim) begin
			emit_try = 1'b1;
			ob = ctx_q.esc.accum;
		end else if (esc) begin
			emit_try = (ctx_q.esc.phase == ESC_D2) || item.in_last;
			ob = accum_new;
		end else if (delim) begin
			emit_try = 1'b0;
			ob = 8'h00;
		end else if (is_pct) begin
			emit_try = item.in_last;
			ob = 8'h00;
		end else begin
			emit_try = 1'b1;
			ob = b;
		end

		part_len = ctx_q.in_value ? val_len_q : key_len_q;
		part_lim = ctx_q.in_value ? value_limit : key_limit;
		keep = (CW'(part_len) < CW'(part_lim)) && (part_len != LEN_MAX);
		have_byte = emit_try && keep;
		drop = emit_try && !keep;
		key_over_new = ctx_q.key_over | (drop && !ctx_q.in_value);
		value_over_new = ctx_q.value_over | (drop && ctx_q.in_value);
		in_value_new = ctx_q.in_value | is_sep;
		end_pair = is_amp || item.in_last;

		res_valid = have_byte || end_pair;
		res.out_byte = have_byte ? ob : 8'h00;
		res.byte_valid = have_byte;
		res.is_value = end_pair ? in_value_new : ctx_q.in_value;
		res.pair_end = end_pair;
		res.key_overflowed = key_over_new;
		res.value_overflowed = value_over_new;
		res.pair_number = ctx_q.pair_cnt;

		ctx_d = ctx_q;
		key_len_d = key_len_q;
		val_len_d = val_len_q;
		if (end_pair) begin
			ctx_d.in_value = 1'b0;
			ctx_d.key_over = 1'b0;
			ctx_d.value_over = 1'b0;
			ctx_d.esc.phase = ESC_NONE;
			ctx_d.esc.accum = 8'h00;
			ctx_d.esc.stopped = 1'b0;
			key_len_d = '0;
			val_len_d = '0;
			if (item.in_last) begin
				ctx_d.pair_cnt = 16'h0000;
			end else if (ctx_q.pair_cnt != PAIR_CNT_MAX) begin
				ctx_d.pair_cnt = ctx_q.pair_cnt + 16'd1;
			end
		end else begin
			ctx_d.in_value = in_value_new;
			ctx_d.key_over = key_over_new;
			ctx_d.value_over = value_over_new;
			if (have_byte && ctx_q.in_value) begin
				val_len_d = val_len_q + LENGTH_WIDTH'(1);
			end
			if (have_byte && !ctx_q.in_value) begin
				key_len_d = key_len_q + LENGTH_WIDTH'(1);
			end
			if (esc && !delim && ctx_q.esc.phase == ESC_D1) begin
				ctx_d.esc.phase = ESC_D2;
				ctx_d.esc.accum = accum_new;
				ctx_d.esc.stopped = stopped_new;
			end else if (esc) begin
				ctx_d.esc.phase = ESC_NONE;
				ctx_d.esc.accum = 8'h00;
				ctx_d.esc.stopped = 1'b0;
			end else if (is_pct) begin
				ctx_d.esc.phase = ESC_D1;
				ctx_d.esc.accum = 8'h00;
				ctx_d.esc.stopped = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for form_urlencoded_pair_parser. A directed table opens
// the run, then random form texts go through several limit settings and a long
// output hold-off. Every accepted byte is run through a local decoder model and
// each result is checked field by field.
// ----------------------------------------------------------------------------

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fup_pkg::*;

	localparam int LEN_W = LENGTH_WIDTH_DEF;
	localparam int LEN_CAP = (1 << LEN_W) - 1;
	localparam int SETTLE_CYCLES = 4;      // output register latency plus margin
	localparam int HOLD_CYCLES = 300;      // long receiver hold-off
	localparam int CYCLE_LIMIT = 2000000;
	localparam int N_SETTINGS = 7;
	localparam int PHASE_ITEMS = 25;       // minimum random bytes per limit setting
	localparam int LONG_PART = 1030;       // just past the widest limit
	localparam int MAX_PRINTS = 40;

	// How a directed row is checked
	typedef enum logic [1:0] {
		ROW_PREDICT,  // compare with the model
		ROW_SILENT,   // no result at all
		ROW_TYPED     // result given in the row
	} row_check_e;

	typedef struct {
		logic [7:0] chr;
		logic last;
		row_check_e check;
		fup_out_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	fup_in_t in_data;
	logic out_valid;
	logic out_stall;
	fup_out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LIMIT_W-1:0] cfg_data;

	// Decoder model state
	logic part_is_value;
	esc_phase_t esc_phase;
	logic [7:0] esc_accum;
	logic esc_stopped;
	logic [LEN_W-1:0] key_len;
	logic [LEN_W-1:0] value_len;
	logic key_over;
	logic value_over;
	logic [15:0] pair_idx;
	logic [LIMIT_W-1:0] key_limit_q;
	logic [LIMIT_W-1:0] value_limit_q;

	fup_out_t pending_results[$];
	logic [7:0] text_q[$];
	int mismatch_count;
	int random_fed;
	bit in_quiet;
	bit out_quiet;
	bit hold_req;

	// Limit settings walked by the random part; zero and full scale included
	logic [LIMIT_W-1:0] key_lims [N_SETTINGS] = '{10'd0, 10'd1023, 10'd3, 10'd1, 10'd6,
		10'd0, 10'd255};
	logic [LIMIT_W-1:0] value_lims [N_SETTINGS] = '{10'd0, 10'd1023, 10'd5, 10'd0, 10'd2,
		10'd1023, 10'd399};

	// Directed opening, starting from reset limits (key 255, value 399).
	// Fields of want: byte, byte_valid, is_value, pair_end, key ovf, value ovf, pair.
	dir_row_t dir_table [27] = '{
		'{"A", 1'b0, ROW_TYPED, {"A", 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
		'{CH_EQ, 1'b0, ROW_SILENT, '0},
		'{8'h00, 1'b0, ROW_TYPED, {8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0}},
		'{8'hFF, 1'b0, ROW_TYPED, {8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0}},
		// a second '=' is plain value data
		'{CH_EQ, 1'b0, ROW_TYPED, {CH_EQ, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0}},
		// '+' is not turned into a space
		'{"+", 1'b0, ROW_TYPED, {"+", 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0}},
		'{CH_AMP, 1'b0, ROW_TYPED, {8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0}},
		// empty pair still ends
		'{CH_AMP, 1'b0, ROW_TYPED, {8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1}},
		'{CH_PCT, 1'b0, ROW_SILENT, '0},
		'{"4", 1'b0, ROW_SILENT, '0},
		'{"a", 1'b0, ROW_TYPED, {8'h4A, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd2}},
		// non-hex second position stops the digits
		'{CH_PCT, 1'b0, ROW_SILENT, '0},
		'{"f", 1'b0, ROW_SILENT, '0},
		'{"G", 1'b0, ROW_TYPED, {8'h0F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd2}},
		// non-hex first position, later digit ignored
		'{CH_PCT, 1'b0, ROW_PREDICT, '0},
		'{"Z", 1'b0, ROW_PREDICT, '0},
		'{"1", 1'b0, ROW_PREDICT, '0},
		// key '=' cuts an escape
		'{CH_PCT, 1'b0, ROW_SILENT, '0},
		'{"7", 1'b0, ROW_SILENT, '0},
		'{CH_EQ, 1'b0, ROW_TYPED, {8'h07, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd2}},
		// '&' cuts an escape and ends the pair in one result
		'{CH_PCT, 1'b0, ROW_SILENT, '0},
		'{"C", 1'b0, ROW_SILENT, '0},
		'{CH_AMP, 1'b0, ROW_TYPED, {8'h0C, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'd2}},
		// end of text cuts an escape
		'{CH_PCT, 1'b0, ROW_SILENT, '0},
		'{"b", 1'b1, ROW_TYPED, {8'h0B, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd3}},
		// lone final '&': one empty pair, pair index back at 0
		'{CH_AMP, 1'b1, ROW_TYPED, {8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0}},
		// text ends right after '%'
		'{CH_PCT, 1'b1, ROW_TYPED, {8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0}}
	};

	form_urlencoded_pair_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Reset once, released on a falling edge
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ---------------------------------------------------------------- model

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		return -1;
	endfunction

	function automatic void esc_clear();
		esc_phase = ESC_NONE;
		esc_accum = 8'h00;
		esc_stopped = 1'b0;
	endfunction

	// Count one decoded byte into the open part; 0 means dropped for length
	function automatic bit admit_byte();
		if (part_is_value) begin
			if (value_len < value_limit_q && int'(value_len) < LEN_CAP) begin
				value_len++;
				return 1'b1;
			end
			value_over = 1'b1;
			return 1'b0;
		end
		if (key_len < key_limit_q && int'(key_len) < LEN_CAP) begin
			key_len++;
			return 1'b1;
		end
		key_over = 1'b1;
		return 1'b0;
	endfunction

	function automatic void model_reset();
		key_limit_q = KEY_LIMIT_RST;
		value_limit_q = VALUE_LIMIT_RST;
		part_is_value = 1'b0;
		esc_clear();
		key_len = '0;
		value_len = '0;
		key_over = 1'b0;
		value_over = 1'b0;
		pair_idx = '0;
	endfunction

	// One raw byte in, at most one decoded result out
	task automatic decode_byte(input fup_in_t item, output bit has_res, output fup_out_t res);
		logic [7:0] ch;
		logic [7:0] ob;
		logic is_amp;
		logic is_sep;
		logic emitted;
		logic closes;
		logic part;
		int nib;
		ch = item.in_byte;
		is_amp = (ch == CH_AMP);
		is_sep = (ch == CH_EQ) && !part_is_value;
		emitted = 1'b0;
		closes = 1'b0;
		ob = 8'h00;
		part = part_is_value;
		if (esc_phase != ESC_NONE && !is_amp && !is_sep) begin
			// digit position of an escape
			nib = nibble_of(ch);
			if (nib < 0) begin
				esc_stopped = 1'b1;
			end else if (!esc_stopped) begin
				esc_accum = {esc_accum[3:0], nib[3:0]};
			end
			if (esc_phase == ESC_D2) begin
				ob = esc_accum;
				emitted = admit_byte();
				esc_clear();
			end else begin
				esc_phase = ESC_D2;
			end
		end else begin
			// a delimiter cuts a pending escape first
			if (esc_phase != ESC_NONE) begin
				ob = esc_accum;
				emitted = admit_byte();
				esc_clear();
			end
			if (is_amp) begin
				closes = 1'b1;
			end else if (is_sep) begin
				part_is_value = 1'b1;
			end else if (ch == CH_PCT) begin
				esc_clear();
				esc_phase = ESC_D1;
			end else begin
				ob = ch;
				emitted = admit_byte();
			end
		end
		// end of text flushes an open escape and closes the pair
		if (item.in_last && !is_amp) begin
			if (esc_phase != ESC_NONE) begin
				ob = esc_accum;
				emitted = admit_byte();
				esc_clear();
			end
			closes = 1'b1;
		end
		has_res = emitted || closes;
		if (closes) part = part_is_value;
		res.out_byte = emitted ? ob : 8'h00;
		res.byte_valid = emitted;
		res.is_value = part;
		res.pair_end = closes;
		res.key_overflowed = key_over;
		res.value_overflowed = value_over;
		res.pair_number = pair_idx;
		if (closes) begin
			part_is_value = 1'b0;
			esc_clear();
			key_len = '0;
			value_len = '0;
			key_over = 1'b0;
			value_over = 1'b0;
			if (item.in_last) pair_idx = '0;
			else if (pair_idx != PAIR_CNT_MAX) pair_idx++;
		end
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string field, input logic [15:0] got,
		input logic [15:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS) begin
			$display("[%0t] %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
		end
	endtask

	task automatic check_result(input fup_out_t got);
		fup_out_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with nothing pending, pair", got.pair_number, 16'h0);
			return;
		end
		want = pending_results.pop_front();
		if (got.out_byte !== want.out_byte)
			report_mismatch("out_byte", 16'(got.out_byte), 16'(want.out_byte));
		if (got.byte_valid !== want.byte_valid)
			report_mismatch("byte_valid", 16'(got.byte_valid), 16'(want.byte_valid));
		if (got.is_value !== want.is_value)
			report_mismatch("is_value", 16'(got.is_value), 16'(want.is_value));
		if (got.pair_end !== want.pair_end)
			report_mismatch("pair_end", 16'(got.pair_end), 16'(want.pair_end));
		if (got.key_overflowed !== want.key_overflowed)
			report_mismatch("key_overflowed", 16'(got.key_overflowed),
				16'(want.key_overflowed));
		if (got.value_overflowed !== want.value_overflowed)
			report_mismatch("value_overflowed", 16'(got.value_overflowed),
				16'(want.value_overflowed));
		if (got.pair_number !== want.pair_number)
			report_mismatch("pair_number", got.pair_number, want.pair_number);
	endtask

	// Result transactions are taken at the rising edge, pre-update values
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			check_result(out_data);
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------- receiver

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Random stalls with calm stretches; a hold request forces a long stall
	initial begin
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				if (out_quiet) begin
					free_left = 0;
				end else if (free_left > 0) begin
					free_left--;
				end else begin
					stall_left = pick_gap();
					free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
						: $urandom_range(0, 4);
				end
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// Present one byte and hold it until the block takes it
	task automatic offer(input fup_in_t item);
		@(negedge clk);
		in_valid = 1'b1;
		in_data = item;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic sender_gap();
		int n;
		n = in_quiet ? 0 : pick_gap();
		if (n > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Send one byte; the expectation is queued at the accepting edge
	task automatic feed(input logic [7:0] chr, input logic last, input row_check_e check,
		input fup_out_t want);
		fup_in_t item;
		fup_out_t res;
		bit has_res;
		item.in_byte = chr;
		item.in_last = last;
		offer(item);
		decode_byte(item, has_res, res);
		if (check == ROW_TYPED) pending_results.push_back(want);
		else if (check == ROW_PREDICT && has_res) pending_results.push_back(res);
		sender_gap();
	endtask

	// Idle the input and wait out every pending result
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_KEY_LIMIT) key_limit_q = val;
		else value_limit_q = val;
	endtask

	// ---------------------------------------------------------------- text builder

	function automatic logic [7:0] hex_char();
		int d;
		d = $urandom_range(0, 15);
		if (d < 10) return 8'("0" + d);
		return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 4);
		if (r < 95) return $urandom_range(5, 12);
		return $urandom_range(13, 40);
	endfunction

	// Escapes are mostly complete; some are short so the next byte cuts them
	function automatic void add_escape();
		int n;
		text_q.push_back(CH_PCT);
		n = ($urandom_range(0, 9) < 8) ? 2 : $urandom_range(0, 1);
		repeat (n) begin
			if ($urandom_range(0, 9) < 8) text_q.push_back(hex_char());
			else text_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void add_part(input int n, input bit value_side);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 55) text_q.push_back(8'($urandom_range("a", "z")));
			else if (r < 62) text_q.push_back("+");
			else if (r < 85) add_escape();
			else if (r < 92 && value_side) text_q.push_back(CH_EQ);
			else text_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// Noisy texts put in_last at random; well-formed ones only on the end byte
	task automatic send_text(input bit noisy);
		logic last;
		for (int i = 0; i < text_q.size(); i++) begin
			last = noisy ? ($urandom_range(0, 7) == 0) : (i == text_q.size() - 1);
			feed(text_q[i], last, ROW_PREDICT, '0);
			random_fed++;
		end
	endtask

	task automatic random_text();
		int pairs;
		bit noisy;
		text_q.delete();
		noisy = ($urandom_range(0, 99) < 12);
		if (noisy) begin
			repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			pairs = $urandom_range(1, 4);
			for (int p = 0; p < pairs; p++) begin
				if (p > 0) text_q.push_back(CH_AMP);
				add_part(pick_len(), 1'b0);
				if ($urandom_range(0, 99) < 85) begin
					text_q.push_back(CH_EQ);
					add_part(pick_len(), 1'b1);
				end
			end
			// trailing '&' closes the text without an extra pair
			if ($urandom_range(0, 99) < 20 || text_q.size() == 0) text_q.push_back(CH_AMP);
		end
		send_text(noisy);
	endtask

	// ---------------------------------------------------------------- main flow

	initial begin
		int phase_start;
		bit hold_done;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_KEY_LIMIT;
		cfg_data = '0;
		in_quiet = 1'b0;
		out_quiet = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		mismatch_count = 0;
		random_fed = 0;
		model_reset();
		wait (arst_n === 1'b1);

		foreach (dir_table[i])
			feed(dir_table[i].chr, dir_table[i].last, dir_table[i].check, dir_table[i].want);
		wait_drained();

		for (int ph = 0; ph < N_SETTINGS; ph++) begin
			write_limit(CFG_KEY_LIMIT, key_lims[ph]);
			write_limit(CFG_VALUE_LIMIT, value_lims[ph]);
			phase_start = random_fed;
			while (random_fed - phase_start < PHASE_ITEMS) begin
				in_quiet = ($urandom_range(0, 9) == 0);
				// long output hold-off while input keeps coming
				if (ph == 2 && !hold_done) begin
					in_quiet = 1'b0;
					hold_req = 1'b1;
					hold_done = 1'b1;
				end
				random_text();
			end
			// one value past the full-scale limit
			if (ph == 1) begin
				in_quiet = 1'b1;
				out_quiet = 1'b1;
				text_q.delete();
				text_q.push_back("k");
				text_q.push_back(CH_EQ);
				repeat (LONG_PART) text_q.push_back(8'($urandom_range("a", "z")));
				send_text(1'b0);
				out_quiet = 1'b0;
			end
			wait_drained();
		end

		// close the text with a final '&'
		in_quiet = 1'b1;
		out_quiet = 1'b1;
		feed(CH_AMP, 1'b1, ROW_PREDICT, '0);
		wait_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
